// ===== hdl/assert_macros.svh =====
// Assertion helpers for clocked properties.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== hdl/nrb_pkg.sv =====
// ----------------------------------------------------------------------------
// nrb_pkg
// Types and codes shared by the retransmission buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package nrb_pkg;
  localparam logic [2:0] KIND_STORE = 3'd0;
  localparam logic [2:0] KIND_GNACK = 3'd1;
  localparam logic [2:0] KIND_RNACK = 3'd2;
  localparam logic [2:0] KIND_TICK  = 3'd3;
  localparam logic [2:0] KIND_STATS = 3'd4;
  localparam logic [1:0] ACT_FORWARD = 2'd0;
  localparam logic [1:0] ACT_RETX    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_STATS   = 2'd3;
  localparam logic [15:0] FAR_HALF = 16'h8000;
  localparam logic [15:0] LATENCY_RESET = 16'd1000;
  localparam int ENTRY_W = 76;
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] seq;
    logic [15:0] mask_or_count;
    logic [11:0] handle;
    logic [47:0] time_now;
  } in_item_t;
  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] out_handle;
    logic [15:0] out_seq;
    logic [31:0] retransmit_count;
    logic        last;
  } out_item_t;
endpackage
`default_nettype wire

// ===== hdl/nrb_ram.sv =====
// ----------------------------------------------------------------------------
// nrb_ram
// Single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module nrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/nack_retransmit_buffer.sv =====
// ----------------------------------------------------------------------------
// nack_retransmit_buffer
// FIFO of sent packets answering NACKs, latency ticks and stats reads.
// ----------------------------------------------------------------------------
// A store forwards the packet, releases the oldest entry when the FIFO is
// full, then appends. A NACK walks the FIFO entries (RAM read, then decide),
// and a tick first computes its age limit with a multiply. A result is shown
// when the next one is found or when the walk ends, so its last flag is known.
// One item at a time.
// Reset (synchronous) empties the FIFO, clears the counter, sets the age limit to 1000 ms.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nack_retransmit_buffer import nrb_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int TICKS_PER_MS = 27000
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [15:0] cfg_data
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_STORE = 8'b00000010,
    S_STATS = 8'b00000100,
    S_MUL   = 8'b00001000,
    S_READ  = 8'b00010000,
    S_EVAL  = 8'b00100000,
    S_APPND = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t state;
  in_item_t req;
  logic [AW-1:0] head;
  logic [CW-1:0] fill;
  logic [CW-1:0] idx;
  logic [31:0] retrans_total;
  logic [15:0] latency_ms;
  logic [15:0] id, mask;
  logic [47:0] limit;
  logic [39:0] prod_lo;
  logic held;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic [15:0] e_seq;
  logic [47:0] e_time;
  logic [11:0] e_handle;

  nrb_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  assign {e_seq, e_time, e_handle} = rdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [CW:0] s;
    s = {1'b0, CW'(h)} + {1'b0, i};
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign raddr = slot(head, idx);
  assign waddr = slot(head, fill);
  assign wdata = {req.seq, req.time_now, req.handle};
  assign we = (state == S_APPND);
  assign in_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE) && !in_valid;

  logic [15:0] seq_dist;
  logic [15:0] mlow, mask_sh;
  logic [4:0] z;
  logic [47:0] age;
  assign seq_dist = e_seq - req.seq;
  assign age = req.time_now - e_time;
  always_comb begin
    z = 5'd0;
    for (int b = 15; b >= 0; b--) if (mask[b]) z = 5'(b);
    mask_sh = 16'((32'(mask) >> z) >> 1);
  end
  assign mlow = id + 16'(z) + 16'd1;

  logic [31:0] sat_inc;
  assign sat_inc = (retrans_total == 32'hFFFF_FFFF) ? retrans_total : retrans_total + 32'd1;

  logic [23:0] tpm;
  assign tpm = 24'(TICKS_PER_MS);

  logic found;
  out_item_t found_item;
  logic walk_end;
  logic can_out;
  logic out_load;
  assign can_out = !out_valid || !out_stall;
  assign walk_end = (idx + CW'(1) >= fill);
  always_comb begin
    found = 1'b0;
    found_item = '{ACT_RETX, e_handle, e_seq, 32'd0, 1'b0};
    case (req.kind)
      KIND_STORE: begin
        found = 1'b1;
        found_item.action = ACT_RELEASE;
      end
      KIND_GNACK: found = (e_seq == id);
      KIND_RNACK: found = (seq_dist <= req.mask_or_count);
      default: begin
        found = (age >= limit);
        found_item.action = ACT_RELEASE;
      end
    endcase
  end
  assign out_load = held && (((state == S_EVAL) && found) || (state == S_DONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      held <= 1'b0;
      head <= '0;
      fill <= '0;
      retrans_total <= '0;
      latency_ms <= LATENCY_RESET;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) latency_ms <= cfg_data;
          if (in_valid) begin
            req <= in_data;
            idx <= '0;
            id <= in_data.seq;
            mask <= in_data.mask_or_count;
            case (in_data.kind)
              KIND_STORE: state <= S_STORE;
              KIND_GNACK, KIND_RNACK: state <= S_READ;
              KIND_TICK: begin
                prod_lo <= 40'(latency_ms) * 40'(tpm);
                state <= S_MUL;
              end
              KIND_STATS: state <= S_STATS;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_STORE: begin
          if (can_out) begin
            out_data <= '{ACT_FORWARD, req.handle, req.seq, 32'd0, 1'b0};
            held <= 1'b1;
            state <= (fill == FULL) ? S_READ : S_APPND;
          end
        end
        S_STATS: begin
          if (can_out) begin
            out_data <= '{ACT_STATS, 12'd0, 16'd0, retrans_total, 1'b0};
            held <= 1'b1;
            retrans_total <= '0;
            state <= S_DONE;
          end
        end
        S_MUL: begin
          limit <= {8'd0, prod_lo};
          state <= S_READ;
        end
        S_READ: begin
          if (idx >= fill) state <= S_DONE;
          else state <= S_EVAL;
        end
        S_EVAL: begin
          if (found && held) begin
            held <= 1'b0;
          end else if (found && can_out) begin
            out_data <= found_item;
            held <= 1'b1;
            case (req.kind)
              KIND_STORE: begin
                head <= slot(head, CW'(1));
                fill <= fill - CW'(1);
                state <= S_APPND;
              end
              KIND_GNACK: begin
                idx <= idx + CW'(1);
                retrans_total <= sat_inc;
                id <= mlow;
                mask <= mask_sh;
                state <= ((mask == '0) || walk_end) ? S_DONE : S_READ;
              end
              KIND_RNACK: begin
                idx <= idx + CW'(1);
                retrans_total <= sat_inc;
                state <= walk_end ? S_DONE : S_READ;
              end
              default: begin
                head <= slot(head, CW'(1));
                fill <= fill - CW'(1);
                state <= (fill == CW'(1)) ? S_DONE : S_READ;
              end
            endcase
          end else if (!found) begin
            case (req.kind)
              KIND_GNACK: begin
                idx <= idx + CW'(1);
                state <= walk_end ? S_DONE : S_READ;
              end
              KIND_RNACK: begin
                idx <= idx + CW'(1);
                state <= (walk_end || (seq_dist < FAR_HALF)) ? S_DONE : S_READ;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_APPND: begin
          fill <= fill + CW'(1);
          state <= S_DONE;
        end
        S_DONE: begin
          if (held) begin
            out_data.last <= 1'b1;
            held <= 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_fill_range, clk, rst, fill <= FULL, "fill count beyond depth")
  `ASSERT_CLK(a_idle_no_stall, clk, rst, (state == S_IDLE) |-> !in_stall, "stall while idle")
  `ASSERT_CLK(a_cfg_idle, clk, rst, (cfg_valid && cfg_ready) |-> (state == S_IDLE),
              "config taken while busy")
  `ASSERT_CLK(a_out_hold, clk, rst,
              (out_valid && out_stall) |=> (out_valid && $stable(out_data)),
              "stalled result changed")
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives stores, NACKs, ticks and stats reads into the retransmission buffer
// and checks every result against a packet FIFO tracked in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class retx_scoreboard;
  localparam int QDEPTH = 64;
  localparam longint unsigned MS_TICKS = 27000;
  logic [15:0] q_seq[QDEPTH];
  logic [47:0] q_time[QDEPTH];
  logic [11:0] q_hdl[QDEPTH];
  int unsigned head;
  int unsigned fill;
  logic [31:0] retx_total;
  logic [15:0] latency_ms;
  nrb_pkg::out_item_t pending[$];
  int unsigned errors;
  int unsigned results_seen;

  function void clear();
    head = 0;
    fill = 0;
    retx_total = 0;
    latency_ms = nrb_pkg::LATENCY_RESET;
    pending.delete();
    errors = 0;
    results_seen = 0;
  endfunction

  function void push(logic [1:0] act, logic [11:0] h, logic [15:0] s, logic [31:0] c);
    nrb_pkg::out_item_t r;
    r.action = act;
    r.out_handle = h;
    r.out_seq = s;
    r.retransmit_count = c;
    r.last = 1'b0;
    pending.push_back(r);
  endfunction

  function void retx(int unsigned slot);
    if (retx_total != 32'hFFFF_FFFF) retx_total++;
    push(nrb_pkg::ACT_RETX, q_hdl[slot], q_seq[slot], 32'd0);
  endfunction

  function void pop_head();
    push(nrb_pkg::ACT_RELEASE, q_hdl[head], q_seq[head], 32'd0);
    head = (head + 1) % QDEPTH;
    fill--;
  endfunction

  function void note_input(nrb_pkg::in_item_t it);
    int unsigned n_before;
    int unsigned slot;
    int unsigned z;
    logic [15:0] id;
    logic [15:0] mask;
    logic [15:0] d;
    logic [47:0] age;
    longint unsigned lim;
    n_before = pending.size();
    case (it.kind)
      nrb_pkg::KIND_STORE: begin
        push(nrb_pkg::ACT_FORWARD, it.handle, it.seq, 32'd0);
        if (fill >= QDEPTH) pop_head();
        slot = (head + fill) % QDEPTH;
        q_seq[slot] = it.seq;
        q_time[slot] = it.time_now;
        q_hdl[slot] = it.handle;
        fill++;
      end
      nrb_pkg::KIND_GNACK: begin
        id = it.seq;
        mask = it.mask_or_count;
        for (int unsigned i = 0; i < fill; i++) begin
          slot = (head + i) % QDEPTH;
          if (q_seq[slot] == id) begin
            retx(slot);
            if (mask == 0) break;
            z = 0;
            while (mask[z] == 1'b0) z++;
            mask = mask >> (z + 1);
            id = id + 16'(z + 1);
          end
        end
      end
      nrb_pkg::KIND_RNACK: begin
        for (int unsigned i = 0; i < fill; i++) begin
          slot = (head + i) % QDEPTH;
          d = q_seq[slot] - it.seq;
          if (d > it.mask_or_count) begin
            if (d < nrb_pkg::FAR_HALF) break;
          end else begin
            retx(slot);
          end
        end
      end
      nrb_pkg::KIND_TICK: begin
        lim = longint'(latency_ms) * MS_TICKS;
        while (fill > 0) begin
          age = it.time_now - q_time[head];
          if (longint'(age) < lim) break;
          pop_head();
        end
      end
      nrb_pkg::KIND_STATS: begin
        push(nrb_pkg::ACT_STATS, 12'd0, 16'd0, retx_total);
        retx_total = 0;
      end
      default: ;
    endcase
    if (pending.size() > n_before) pending[pending.size() - 1].last = 1'b1;
  endfunction

  function void check_result(nrb_pkg::out_item_t got);
    nrb_pkg::out_item_t want;
    results_seen++;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
    end
  endfunction
endclass

module testbench;
  import nrb_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit hold_recv;
  int unsigned items_sent;
  logic [15:0] base_seq;
  logic [47:0] clock_now;
  retx_scoreboard sb;

  nack_retransmit_buffer #(.DEPTH(64), .TICKS_PER_MS(27000)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL nack_retransmit_buffer");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    if (rst || hold_recv) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  initial begin
    hold_recv <= 1'b1;
    wait (rst === 1'b0);
    repeat (400) @(posedge clk);
    hold_recv <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(99) < 1) begin
        hold_recv <= 1'b1;
        repeat ($urandom_range(600, 300)) @(posedge clk);
        hold_recv <= 1'b0;
      end
    end
  end

  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_fields(logic [2:0] k, logic [15:0] s, logic [15:0] mc,
                             logic [11:0] h, logic [47:0] t);
    in_item_t it;
    it.kind = k;
    it.seq = s;
    it.mask_or_count = mc;
    it.handle = h;
    it.time_now = t;
    send(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_latency(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.latency_ms = v;
  endtask

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    clock_now = clock_now + 48'($urandom_range(40000000));
    if (pick < 50) begin
      base_seq++;
      send_fields(KIND_STORE, base_seq, 16'($urandom), 12'($urandom), clock_now);
    end else if (pick < 68) begin
      send_fields(KIND_GNACK, base_seq - 16'($urandom_range(70)), 16'($urandom),
                  12'($urandom), 48'($urandom));
    end else if (pick < 82) begin
      send_fields(KIND_RNACK, base_seq - 16'($urandom_range(70)),
                  16'($urandom_range(20)), 12'($urandom), 48'($urandom));
    end else if (pick < 90) begin
      send_fields(KIND_TICK, 16'($urandom), 16'($urandom), 12'($urandom), clock_now);
    end else if (pick < 96) begin
      send_fields(KIND_STATS, 16'($urandom), 16'($urandom), 12'($urandom), 48'($urandom));
    end else begin
      send_fields(3'($urandom_range(7, 5)), 16'($urandom), 16'($urandom),
                  12'($urandom), {$urandom, 16'($urandom)});
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    items_sent = 0;
    send_idle_pct = 7;
    recv_idle_pct = 74;
    base_seq = 16'hFFF0;
    clock_now = 48'hFFFF_F000_0000;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_fields(KIND_TICK, 16'd0, 16'd0, 12'd0, 48'd0);
    send_fields(KIND_GNACK, 16'd5, 16'hFFFF, 12'd0, 48'd0);
    send_fields(KIND_STATS, 16'hFFFF, 16'hFFFF, 12'hFFF, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 66; i++) begin
      base_seq++;
      send_fields(KIND_STORE, base_seq, 16'($urandom), (i == 0) ? 12'hFFF : 12'(i),
                  (i == 1) ? 48'hFFFF_FFFF_FFFF : clock_now + 48'(i));
    end
    send_fields(KIND_GNACK, base_seq - 16'd40, 16'b1000_0000_0010_0101, 12'd0, 48'd0);
    send_fields(KIND_GNACK, base_seq - 16'd3, 16'h0000, 12'd0, 48'd0);
    send_fields(KIND_GNACK, 16'hFFFF, 16'hFFFF, 12'd0, 48'd0);
    send_fields(KIND_RNACK, base_seq - 16'd20, 16'd10, 12'd0, 48'd0);
    send_fields(KIND_RNACK, 16'd0, 16'hFFFF, 12'd0, 48'd0);
    send_fields(KIND_RNACK, base_seq + 16'd5, 16'd2, 12'd0, 48'd0);
    send_fields(KIND_STATS, 16'd0, 16'd0, 12'd0, 48'd0);
    send_fields(3'd7, 16'hFFFF, 16'hFFFF, 12'hFFF, 48'hFFFF_FFFF_FFFF);
    send_fields(KIND_TICK, 16'd0, 16'd0, 12'd0, clock_now + 48'd27000000);
    drain();

    write_latency(16'd0);
    send_fields(KIND_TICK, 16'd0, 16'd0, 12'd0, clock_now);
    drain();
    write_latency(16'hFFFF);
    for (int i = 0; i < 15; i++) random_item();
    drain();

    write_latency(16'd1);
    send_idle_pct = 74;
    recv_idle_pct = 7;
    for (int i = 0; i < 15; i++) random_item();
    drain();

    write_latency(16'd1000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 15; i++) random_item();
    send_fields(KIND_STATS, 16'd0, 16'd0, 12'd0, 48'd0);
    drain();

    $display("covered %0d transactions, %0d results, latencies 0/1/1000/65535",
             items_sent, sb.results_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS nack_retransmit_buffer");
    end else begin
      $display("FAIL nack_retransmit_buffer");
    end
    $finish;
  end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/nrb_pkg.sv
hdl/nrb_ram.sv
hdl/nack_retransmit_buffer.sv
bench/testbench.sv
